@@ rtl/ilie_pkg.sv @@
`default_nettype none
package ilie_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 9;
  localparam int WORD_W = 64;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;

  localparam int IN_USED_W   = CMD_W + POS_W + WORD_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = WORD_W + LEN_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_INDEX = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic idx_init;
    logic idx_step;
    logic rd_direct;
    logic rd_src;
    logic wr_shift;
    logic wr_word;
    logic cnt_inc;
    logic cnt_dec;
    logic res_load;
  } ilie_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ok;
    logic             more;
  } ilie_stat_t;

endpackage
`default_nettype wire

@@ rtl/ilie_ctrl.sv @@
`default_nettype none
module ilie_ctrl
  import ilie_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic       m_tready,
  output logic            m_tvalid,
  input  wire ilie_stat_t stat,
  output ilie_ctl_t       ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT,
    S_CHECK,
    S_MOVE,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.check  = 1'b1;
        state_next = S_FINISH;
        if (stat.ok) begin
          case (stat.cmd)
            CMD_READ: begin
              ctl.rd_direct = 1'b1;
              state_next    = S_WAIT;
            end
            CMD_POP: begin
              ctl.rd_direct = 1'b1;
              ctl.cnt_dec   = 1'b1;
              state_next    = S_WAIT;
            end
            CMD_WRITE: begin
              ctl.wr_word = 1'b1;
            end
            CMD_PUSH: begin
              ctl.wr_word = 1'b1;
              ctl.cnt_inc = 1'b1;
            end
            CMD_INSERT, CMD_ERASE: begin
              ctl.idx_init = 1'b1;
              state_next   = S_CHECK;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_CHECK: begin
        if (stat.more) begin
          ctl.rd_src = 1'b1;
          state_next = S_MOVE;
        end else begin
          // shift done: drop the new word in, or shorten the list
          if (stat.cmd == CMD_INSERT) begin
            ctl.wr_word = 1'b1;
            ctl.cnt_inc = 1'b1;
          end else begin
            ctl.cnt_dec = 1'b1;
          end
          state_next = S_FINISH;
        end
      end
      S_MOVE: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_step = 1'b1;
        state_next   = S_CHECK;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/ilie_dp.sv @@
`default_nettype none
module ilie_dp
  import ilie_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_TDATA_W-1:0]  in_data,
  input  wire ilie_ctl_t              ctl,
  output ilie_stat_t                  stat,
  output logic [OUT_TDATA_W-1:0]      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [STAT_W-1:0] st_q;
  logic [WORD_W-1:0] rdata;

  logic [PW-1:0]     posx, cntx, idxx, depthx;
  logic [CW-1:0]     idx_dn, idx_up, cnt_dn;
  logic [STAT_W-1:0] st_comb;
  logic              known;
  logic [AW-1:0]     src_addr, dst_addr, direct_addr, word_addr, rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic [WORD_W-1:0] wr_data, word_res;

  assign posx   = PW'(pos_q);
  assign cntx   = PW'(count);
  assign idxx   = PW'(idx);
  assign depthx = PW'(DEPTH);
  assign idx_dn = idx - CW'(1);
  assign idx_up = idx + CW'(1);
  assign cnt_dn = count - CW'(1);
  assign known  = (cmd_q <= CMD_POP);

  always_comb begin
    st_comb = ST_OK;
    case (cmd_q)
      CMD_READ, CMD_WRITE, CMD_ERASE: begin
        if (posx >= cntx) st_comb = ST_INDEX;
      end
      CMD_INSERT: begin
        if (cntx == depthx) begin
          st_comb = ST_FULL;
        end else if (posx > cntx) begin
          st_comb = ST_INDEX;
        end
      end
      CMD_PUSH: begin
        if (cntx == depthx) st_comb = ST_FULL;
      end
      CMD_POP: begin
        if (count == '0) st_comb = ST_EMPTY;
      end
      default: begin
        st_comb = ST_OK;
      end
    endcase
  end

  always_comb begin
    stat.cmd  = cmd_q;
    stat.ok   = known && (st_comb == ST_OK);
    stat.more = (cmd_q == CMD_INSERT) ? (idxx > posx) : ((idxx + PW'(1)) < cntx);
  end

  assign src_addr    = (cmd_q == CMD_INSERT) ? idx_dn[AW-1:0] : idx_up[AW-1:0];
  assign dst_addr    = idx[AW-1:0];
  assign direct_addr = (cmd_q == CMD_POP) ? cnt_dn[AW-1:0] : posx[AW-1:0];
  assign word_addr   = (cmd_q == CMD_PUSH) ? count[AW-1:0] : posx[AW-1:0];

  assign rd_en   = ctl.rd_src | ctl.rd_direct;
  assign rd_addr = ctl.rd_src ? src_addr : direct_addr;
  assign wr_en   = ctl.wr_shift | ctl.wr_word;
  assign wr_addr = ctl.wr_shift ? dst_addr : word_addr;
  assign wr_data = ctl.wr_shift ? rdata : word_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count <= cnt_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= in_data[CMD_W-1:0];
      pos_q  <= in_data[CMD_W+POS_W-1:CMD_W];
      word_q <= in_data[IN_USED_W-1:CMD_W+POS_W];
    end
    if (ctl.check) begin
      st_q <= st_comb;
    end
    if (ctl.idx_init) begin
      idx <= (cmd_q == CMD_INSERT) ? count : posx[CW-1:0];
    end else if (ctl.idx_step) begin
      idx <= (cmd_q == CMD_INSERT) ? idx_dn : idx_up;
    end
  end

  assign word_res = (((cmd_q == CMD_READ) || (cmd_q == CMD_POP)) && (st_q == ST_OK))
                    ? rdata : '0;

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_data <= {{OUT_PAD_W{1'b0}}, st_q, cntx[LEN_W-1:0], word_res};
    end
  end

endmodule
`default_nettype wire

@@ rtl/indexed_list_insert_erase.sv @@
// Per request: write, push and rejected requests go from decode to finish; read and
// pop pass a wait state; insert and erase repeat check and move per moved entry.
// One request at a time; the next is taken in the cycle after the result is loaded.
// Insert and erase move entries one at a time through the single memory port pair.
// Synchronous active-high reset empties the list; entry contents are not cleared.
`default_nettype none
module indexed_list_insert_erase
  import ilie_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // command[2:0], position[11:3], word_in[75:12], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // word_out[63:0], length_now[72:64], status[74:73], zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  ilie_ctl_t  ctl;
  ilie_stat_t stat;

  ilie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .stat     (stat),
    .ctl      (ctl)
  );

  ilie_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .ctl      (ctl),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/ilie_chk.sv @@
`default_nettype none
module ilie_chk
  import ilie_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  logic [LEN_W-1:0]  len;
  logic [STAT_W-1:0] st;

  assign len = m_tdata[WORD_W+LEN_W-1:WORD_W];
  assign st  = m_tdata[OUT_USED_W-1:WORD_W+LEN_W];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_EMPTY) |-> (len == '0) && (m_tdata[WORD_W-1:0] == '0))
    else $error("empty status with nonzero length or word");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 511) || (int'(len) <= DEPTH))
    else $error("length beyond depth");

endmodule

bind indexed_list_insert_erase ilie_chk #(.DEPTH(DEPTH)) u_ilie_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
